// ===== rtl/biq_pkg.sv =====
// Shared types, constants and the term schedule for the biquad filter unit.
package biq_pkg;

  // Default field widths
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 24;

  // Multiplier digit width: coefficient bits consumed per cycle
  localparam int DIGIT_BITS = 4;

  // Configuration register index width and codes
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FORM = 3'd0,
    REG_A0   = 3'd1,
    REG_A1   = 3'd2,
    REG_A2   = 3'd3,
    REG_B1   = 3'd4,
    REG_B2   = 3'd5
  } cfg_reg_e;

  // Term counter width (at most six product terms per sample)
  localparam int TERM_BITS = 3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_RND
  } state_e;

  // Coefficient operand of a product term
  typedef enum logic [2:0] {
    C_A0,
    C_A1,
    C_A2,
    C_B1,
    C_B2,
    C_ONE
  } coef_sel_e;

  // Sample operand of a product term
  typedef enum logic [2:0] {
    S_X,
    S_X1,
    S_X2,
    S_Y1,
    S_Y2,
    S_W,
    S_W1,
    S_W2
  } src_sel_e;

  // One entry of the term schedule
  typedef struct packed {
    coef_sel_e coef;
    src_sel_e  src;
    logic      neg;      // subtract product from the sum
    logic      grp_end;  // last term of a sum, round next
    logic      is_mid;   // the rounded sum is the form II intermediate
  } term_t;

  // Term schedule. Form I: a0*x + a1*x1 + a2*x2 - b1*y1 - b2*y2.
  // Form II: w = x - b1*w1 - b2*w2, then y = a0*w + a1*w1 + a2*w2.
  function automatic term_t term_lookup(input logic form_ii,
                                        input logic [TERM_BITS-1:0] idx);
    term_t t;
    t = '{coef: C_A0, src: S_X, neg: 1'b0, grp_end: 1'b1, is_mid: 1'b0};
    if (!form_ii) begin
      case (idx)
        3'd0: t = '{coef: C_A0, src: S_X,  neg: 1'b0, grp_end: 1'b0, is_mid: 1'b0};
        3'd1: t = '{coef: C_A1, src: S_X1, neg: 1'b0, grp_end: 1'b0, is_mid: 1'b0};
        3'd2: t = '{coef: C_A2, src: S_X2, neg: 1'b0, grp_end: 1'b0, is_mid: 1'b0};
        3'd3: t = '{coef: C_B1, src: S_Y1, neg: 1'b1, grp_end: 1'b0, is_mid: 1'b0};
        3'd4: t = '{coef: C_B2, src: S_Y2, neg: 1'b1, grp_end: 1'b1, is_mid: 1'b0};
        default: t = '{coef: C_A0, src: S_X, neg: 1'b0, grp_end: 1'b1, is_mid: 1'b0};
      endcase
    end else begin
      case (idx)
        3'd0: t = '{coef: C_ONE, src: S_X,  neg: 1'b0, grp_end: 1'b0, is_mid: 1'b0};
        3'd1: t = '{coef: C_B1,  src: S_W1, neg: 1'b1, grp_end: 1'b0, is_mid: 1'b0};
        3'd2: t = '{coef: C_B2,  src: S_W2, neg: 1'b1, grp_end: 1'b1, is_mid: 1'b1};
        3'd3: t = '{coef: C_A0,  src: S_W,  neg: 1'b0, grp_end: 1'b0, is_mid: 1'b0};
        3'd4: t = '{coef: C_A1,  src: S_W1, neg: 1'b0, grp_end: 1'b0, is_mid: 1'b0};
        3'd5: t = '{coef: C_A2,  src: S_W2, neg: 1'b0, grp_end: 1'b1, is_mid: 1'b0};
        default: t = '{coef: C_A0, src: S_X, neg: 1'b0, grp_end: 1'b1, is_mid: 1'b0};
      endcase
    end
    return t;
  endfunction

endpackage

// ===== rtl/biquad_iir_filter_unit.sv =====
// Biquad IIR filter, direct form I or II, with a digit-serial multiply-accumulate.
// Each product term is a load, one 4-bit coefficient digit per cycle, then an add,
// with NDIG = ceil(COEF_BITS/4) digits per coefficient.
// Form I: 5 terms and one rounding step; form II: 6 terms and two rounding steps.
// A sample is accepted only when the last is done; final rounding waits for a free output.
// Reset clears history, coefficients to a0 = 1.0 and others 0, form I; no clearing pass.
module biquad_iir_filter_unit #(
  parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = biq_pkg::COEF_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [biq_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [COEF_BITS-1:0]              cfg_data_i,
  // sample input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  // sample output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o
);
  import biq_pkg::*;

  localparam int NDIG   = (COEF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int CW_EXT = NDIG * DIGIT_BITS;         // sign-extended coefficient
  localparam int PW     = SAMPLE_BITS + DIGIT_BITS + 1; // running partial product
  localparam int FULL_W = PW + CW_EXT;
  localparam int ACC_W  = SAMPLE_BITS + COEF_BITS + 2;
  localparam int FRAC   = COEF_BITS - 2;
  localparam int RND_W  = ACC_W - FRAC;
  localparam int CNT_W  = $clog2(NDIG);

  localparam logic [COEF_BITS-1:0] COEF_ONE = {2'b01, {(COEF_BITS-2){1'b0}}};
  localparam logic [ACC_W-1:0]     HALF     = ACC_W'(1) << (FRAC - 1);
  localparam logic [SAMPLE_BITS-1:0] SMAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration registers
  logic                        form_q;
  logic signed [COEF_BITS-1:0] a0_q, a1_q, a2_q, b1_q, b2_q;

  // filter history
  logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q, w1_q, w2_q;

  // per-sample working registers
  logic signed [SAMPLE_BITS-1:0] x_q, w_q, mcand_q;
  logic [CW_EXT-1:0]             coef_sr_q;
  logic signed [PW-1:0]          ph_q;
  logic [CW_EXT-1:0]             pl_q;
  logic [CNT_W-1:0]              dig_cnt_q;
  logic [TERM_BITS-1:0]          term_q;
  logic signed [ACC_W-1:0]       acc_q;

  // output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  state_e state_q, state_d;
  term_t  cur;

  // control strobes
  logic start, load, mul_step, acc_add, mid_done, fin, term_inc;

  assign cur = term_lookup(form_q, term_q);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      form_q <= 1'b0;
      a0_q   <= COEF_ONE;
      a1_q   <= '0;
      a2_q   <= '0;
      b1_q   <= '0;
      b2_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FORM: form_q <= cfg_data_i[0];
        REG_A0:   a0_q   <= cfg_data_i;
        REG_A1:   a1_q   <= cfg_data_i;
        REG_A2:   a2_q   <= cfg_data_i;
        REG_B1:   b1_q   <= cfg_data_i;
        REG_B2:   b2_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and strobes
  always_comb begin
    state_d  = state_q;
    start    = 1'b0;
    load     = 1'b0;
    mul_step = 1'b0;
    acc_add  = 1'b0;
    mid_done = 1'b0;
    fin      = 1'b0;
    term_inc = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          start   = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        load    = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        mul_step = 1'b1;
        if (dig_cnt_q == CNT_W'(NDIG - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_add = 1'b1;
        if (cur.grp_end) begin
          state_d = ST_RND;
        end else begin
          term_inc = 1'b1;
          state_d  = ST_LOAD;
        end
      end
      ST_RND: begin
        if (cur.is_mid) begin
          mid_done = 1'b1;
          term_inc = 1'b1;
          state_d  = ST_LOAD;
        end else if (!out_valid_q || out_ready_i) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Operand selection for the next product term
  logic [COEF_BITS-1:0]          coef_mux;
  logic signed [SAMPLE_BITS-1:0] src_mux;

  always_comb begin
    case (cur.coef)
      C_A0:    coef_mux = a0_q;
      C_A1:    coef_mux = a1_q;
      C_A2:    coef_mux = a2_q;
      C_B1:    coef_mux = b1_q;
      C_B2:    coef_mux = b2_q;
      C_ONE:   coef_mux = COEF_ONE;
      default: coef_mux = a0_q;
    endcase
    case (cur.src)
      S_X:     src_mux = x_q;
      S_X1:    src_mux = x1_q;
      S_X2:    src_mux = x2_q;
      S_Y1:    src_mux = y1_q;
      S_Y2:    src_mux = y2_q;
      S_W:     src_mux = w_q;
      S_W1:    src_mux = w1_q;
      S_W2:    src_mux = w2_q;
      default: src_mux = x_q;
    endcase
  end

  // Digit step: sample times one coefficient digit, top digit signed
  logic                        last_dig;
  logic signed [DIGIT_BITS:0]  dig_s;
  logic signed [PW-1:0]        pp, psum;
  logic signed [FULL_W-1:0]    prod_full;
  logic signed [ACC_W-1:0]     prod;

  assign last_dig  = (dig_cnt_q == CNT_W'(NDIG - 1));
  assign dig_s     = {last_dig & coef_sr_q[DIGIT_BITS-1], coef_sr_q[DIGIT_BITS-1:0]};
  assign pp        = mcand_q * dig_s;
  assign psum      = ph_q + pp;
  assign prod_full = {ph_q, pl_q};
  assign prod      = $signed(prod_full[ACC_W-1:0]);

  // Round half up, shift to sample scale, saturate
  logic [ACC_W-1:0]              rsum;
  logic [RND_W-1:0]              rshift;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          in_range;

  assign rsum     = acc_q + HALF;
  assign rshift   = rsum[ACC_W-1:FRAC];
  assign in_range = (rshift[RND_W-1:SAMPLE_BITS-1] == '0) ||
                    (rshift[RND_W-1:SAMPLE_BITS-1] == '1);
  assign sat      = in_range ? rshift[SAMPLE_BITS-1:0] :
                    (rshift[RND_W-1] ? SMIN : SMAX);

  // Serial multiplier, accumulator and term counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q    <= '0;
      dig_cnt_q <= '0;
    end else begin
      if (start) begin
        term_q <= '0;
      end else if (term_inc) begin
        term_q <= term_q + TERM_BITS'(1);
      end
      if (load) begin
        dig_cnt_q <= '0;
      end else if (mul_step) begin
        dig_cnt_q <= dig_cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      x_q   <= sample_in_i;
      acc_q <= '0;
    end
    if (load) begin
      mcand_q   <= src_mux;
      coef_sr_q <= CW_EXT'($signed(coef_mux));
      ph_q      <= '0;
    end
    if (mul_step) begin
      ph_q      <= psum >>> DIGIT_BITS;
      pl_q      <= {psum[DIGIT_BITS-1:0], pl_q[CW_EXT-1:DIGIT_BITS]};
      coef_sr_q <= coef_sr_q >> DIGIT_BITS;
    end
    if (acc_add) begin
      acc_q <= cur.neg ? (acc_q - prod) : (acc_q + prod);
    end
    if (mid_done) begin
      w_q   <= sat;
      acc_q <= '0;
    end
  end

  // History update when the sample completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
      w1_q <= '0;
      w2_q <= '0;
    end else if (fin) begin
      if (!form_q) begin
        x2_q <= x1_q;
        x1_q <= x_q;
        y2_q <= y1_q;
        y1_q <= sat;
      end else begin
        w2_q <= w1_q;
        w1_q <= w_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_q <= sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // Checks
  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_LOAD && term_q == '0))
    else $error("accepted transaction did not start at the first term");

  a_acc_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> ($past(state_q) == ST_MUL && $past(last_dig)))
    else $error("accumulate without a finished product");

  a_rnd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RND && !cur.is_mid && out_valid_q && !out_ready_i)
      |=> (state_q == ST_RND && $stable(acc_q) && $stable(y1_q) && $stable(w1_q)))
    else $error("result overwrote a pending output or history moved");

endmodule

// ===== bench/biquad_iir_filter_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the biquad filter unit: both forms, directed and random samples.
module biquad_iir_filter_unit_tb;
  import biq_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int CB = COEF_BITS_DEF;
  localparam int FRAC = CB - 2;
  localparam longint Q_ONE = longint'(1) << FRAC;
  localparam longint S_MAX = (longint'(1) << (SB - 1)) - 1;
  localparam longint S_MIN = -S_MAX - 1;
  // indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 120;

  typedef logic signed [SB-1:0] smp_t;
  typedef logic signed [CB-1:0] coef_t;

  localparam coef_t K_MAX = {1'b0, {(CB - 1){1'b1}}};
  localparam coef_t K_MIN = {1'b1, {(CB - 1){1'b0}}};
  localparam coef_t K_ONE = coef_t'(Q_ONE);

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [CB-1:0]           cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  smp_t                    sample_in_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  smp_t                    sample_out_o;

  biquad_iir_filter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the filter settings and history
  logic  filt_form2 = 1'b0;
  coef_t k_a0 = K_ONE, k_a1 = '0, k_a2 = '0, k_b1 = '0, k_b2 = '0;
  smp_t  x_d1 = '0, x_d2 = '0, y_d1 = '0, y_d2 = '0, w_d1 = '0, w_d2 = '0;

  smp_t samples_pending[$];
  smp_t expected_out[$];
  int   n_pushed = 0, n_checked = 0, n_errors = 0;
  int   n_form2 = 0, n_clipped = 0, n_writes = 0, n_settings = 0;
  int   send_gap = 0, hold_cnt = 0;
  logic quiet = 1'b0;
  smp_t want;

  function automatic longint mul(coef_t c, smp_t s);
    return longint'(c) * longint'(s);
  endfunction

  // round to nearest (ties up), back to sample scale, clamp
  function automatic smp_t round_sat(longint acc);
    longint r;
    r = (acc + (Q_ONE >>> 1)) >>> FRAC;
    if (r > S_MAX) r = S_MAX;
    else if (r < S_MIN) r = S_MIN;
    return smp_t'(r);
  endfunction

  // Next output for one accepted sample; advances the selected form's history only
  function automatic smp_t biquad_predict(smp_t x);
    longint acc;
    smp_t   y, w;
    if (!filt_form2) begin
      acc = mul(k_a0, x) + mul(k_a1, x_d1) + mul(k_a2, x_d2)
          - mul(k_b1, y_d1) - mul(k_b2, y_d2);
      y = round_sat(acc);
      x_d2 = x_d1;
      x_d1 = x;
      y_d2 = y_d1;
      y_d1 = y;
    end else begin
      acc = longint'(x) * Q_ONE - mul(k_b1, w_d1) - mul(k_b2, w_d2);
      w = round_sat(acc);
      acc = mul(k_a0, w) + mul(k_a1, w_d1) + mul(k_a2, w_d2);
      y = round_sat(acc);
      w_d2 = w_d1;
      w_d1 = w;
      n_form2++;
    end
    if (y == smp_t'(S_MAX) || y == smp_t'(S_MIN)) n_clipped++;
    return y;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic smp_t rand_sample();
    case ($urandom_range(0, 7))
      0, 1: return smp_t'($urandom());
      2, 3, 4, 5: return smp_t'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
      6: return $urandom_range(0, 1) ? smp_t'(S_MAX) : smp_t'(S_MIN);
      default: return '0;
    endcase
  endfunction

  function automatic coef_t rand_gain(longint lim);
    return coef_t'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
  endfunction

  task automatic push(smp_t s);
    samples_pending.push_back(s);
    n_pushed++;
  endtask

  // register write; only called with nothing in flight
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FORM: filt_form2 = data[0];
      REG_A0:   k_a0 = coef_t'(data);
      REG_A1:   k_a1 = coef_t'(data);
      REG_A2:   k_a2 = coef_t'(data);
      REG_B1:   k_b1 = coef_t'(data);
      REG_B2:   k_b2 = coef_t'(data);
      default:  ;
    endcase
    n_writes++;
  endtask

  task automatic set_filter(input logic [CB-1:0] form_word,
                            input coef_t a0, a1, a2, b1, b2);
    write_reg(REG_FORM, form_word);
    write_reg(REG_A0, a0);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    n_settings++;
  endtask

  // block until every queued sample has come back out
  task automatic wait_idle();
    while (n_checked < n_pushed) @(posedge clk_i);
  endtask

  // Driver: presents queued samples, predicts on each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_out.push_back(biquad_predict(sample_in_i));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (samples_pending.size() != 0) begin
          in_valid_i  <= 1'b1;
          sample_in_i <= samples_pending.pop_front();
          send_gap = idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transaction, applies random backpressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_out.size() == 0) begin
          $display("%0t: sample_out %0d with no sample pending", $time, sample_out_o);
          n_errors++;
        end else begin
          want = expected_out.pop_front();
          n_checked++;
          if (sample_out_o !== want) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want, sample_out_o);
            n_errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 5) == 0) hold_cnt = idle_len();
      end
    end
  end

  // Stimulus
  initial begin
    int ph, i;
    logic [CB-1:0] form_word;
    coef_t b2v;
    longint lim;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings pass samples straight through
    push(smp_t'(S_MAX));
    push(smp_t'(S_MIN));
    push('0);
    push(smp_t'(-1));
    push(smp_t'(1));
    push(smp_t'(24'h555555));
    push(smp_t'(24'hAAAAAA));
    wait_idle();

    // form I at coefficient extremes, saturation both ways; spare indexes dropped
    write_reg(REG_SPARE_LO, CB'($urandom()));
    write_reg(REG_SPARE_HI, CB'($urandom()));
    set_filter('0, K_MAX, K_MIN, K_MAX, K_MIN, K_MAX);
    push(smp_t'(S_MAX));
    push(smp_t'(S_MAX));
    push(smp_t'(S_MIN));
    push(smp_t'(S_MIN));
    push('0);
    push(smp_t'(S_MAX));
    wait_idle();

    // form II, upper bits of the form word set
    set_filter({CB{1'b1}}, coef_t'(Q_ONE / 2), coef_t'(Q_ONE / 4), coef_t'(-Q_ONE / 4),
               coef_t'(-Q_ONE / 2), coef_t'(Q_ONE / 4));
    push(smp_t'(S_MAX));
    push('0);
    push(smp_t'(S_MIN));
    push(smp_t'(1000));
    push(smp_t'(-1));
    push(smp_t'(S_MAX));
    wait_idle();

    // switch forms back and forth: each resumes from its held history
    write_reg(REG_FORM, {{(CB - 1){1'b1}}, 1'b0});
    push(smp_t'(12345));
    push(smp_t'(-54321));
    push(smp_t'(S_MIN));
    wait_idle();
    write_reg(REG_FORM, CB'(1));
    push(smp_t'(777));
    push(smp_t'(S_MAX));
    push('0);
    wait_idle();

    // random settings; mostly stable filters, every fourth wild
    for (ph = 0; ph < 12; ph++) begin
      quiet = (ph % 4 == 2);
      form_word = CB'($urandom());
      form_word[0] = ph[0];
      if (ph == 11) begin
        set_filter(form_word, K_MIN, K_MAX, K_MIN, K_MAX, K_MIN);
      end else if (ph % 4 == 3) begin
        set_filter(form_word, coef_t'($urandom()), coef_t'($urandom()), coef_t'($urandom()),
                   coef_t'($urandom()), coef_t'($urandom()));
      end else begin
        b2v = rand_gain(Q_ONE * 4 / 5);
        lim = ((Q_ONE + longint'(b2v)) * 9) / 10;
        set_filter(form_word, rand_gain(Q_ONE), rand_gain(Q_ONE / 2), rand_gain(Q_ONE / 2),
                   rand_gain(lim), b2v);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CB'($urandom()));
      for (i = 0; i < 90; i++) push(rand_sample());
      wait_idle();
    end

    quiet = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run: %0d samples checked over %0d filter settings, %0d in form II",
             n_checked, n_settings, n_form2);
    $display("run: %0d register writes, %0d outputs at full scale, %0d errors",
             n_writes, n_clipped, n_errors);
    if (n_errors == 0 && expected_out.size() == 0) begin
      $display("biquad_iir_filter_unit_tb: done, clean");
    end else begin
      $display("biquad_iir_filter_unit_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("%0t: timeout, %0d of %0d samples returned", $time, n_checked, n_pushed);
    $display("biquad_iir_filter_unit_tb: done, errors");
    $finish;
  end

endmodule
